### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker file of this block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset.
`define VPTL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Checked at every edge, reset included.
`define VPTL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) \
    else $error(msg);

`endif

### design/vptl_pkg.sv
// ----------------------------------------------------------------------------
// vptl_pkg
// Types, codes and defaults of the voice program table lookup.
// ----------------------------------------------------------------------------
package vptl_pkg;

  localparam int unsigned TableDepthDefault = 256;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_BEST  = 2'd1;
  localparam logic [1:0] OP_EXCL  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic       fm;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] pgm;
    logic [7:0] drum;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

endpackage

### design/vptl_ram.sv
// ----------------------------------------------------------------------------
// vptl_ram
// Generic single-port RAM, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
module vptl_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/voice_program_table_lookup.sv
// ----------------------------------------------------------------------------
// voice_program_table_lookup
// Voice descriptor table with append, best-match and exclusive lookup.
// ----------------------------------------------------------------------------
// One item is handled at a time; the table sits in a single-port RAM read
// one entry per cycle, which sets the timing. An add, the spare op code or
// a lookup on an empty table goes straight to its result; a best-match
// lookup scans every stored entry (a second time in the drum pass), and an
// exclusive lookup scans from the newest entry and stops when it hits. A
// finished result sits in the output register, so the next item can be
// taken while it waits.
module voice_program_table_lookup #(
  parameter int unsigned TableDepth = vptl_pkg::TableDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] op_i,
  input  logic       is_fm_i,
  input  logic [7:0] bank_msb_i,
  input  logic [7:0] bank_lsb_i,
  input  logic [7:0] program_req_i,
  input  logic [7:0] drum_note_i,
  input  logic [7:0] note_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] entry_index_o
);
  import vptl_pkg::*;

  localparam int unsigned AW = $clog2(TableDepth);
  localparam int unsigned CW = $clog2(TableDepth + 1);

  state_e state_q, state_d;

  logic [CW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW-1:0] pidx_q, pidx_d;
  logic [AW-1:0] best_q, best_d;
  logic [2:0]    score_q, score_d;
  logic          found_q, found_d;
  logic          pend_q, pend_d;
  logic          issuing_q, issuing_d;
  logic          drum_pass_q, drum_pass_d;

  logic [1:0]    op_q, op_d;
  logic [7:0]    msb_q, msb_d;
  logic [7:0]    lsb_q, lsb_d;
  logic [7:0]    pgm_q, pgm_d;
  logic [7:0]    note_q, note_d;

  logic [1:0]    res_status_q, res_status_d;
  logic [7:0]    res_idx_q, res_idx_d;

  logic          out_valid_q;
  logic [1:0]    out_status_q;
  logic [7:0]    out_index_q;

  logic          in_acc, out_load, tbl_full, rev;
  logic          ram_we;
  logic [AW-1:0] ram_addr, last_idx, end_addr;
  logic [EntryW-1:0] ram_rdata;
  entry_t        wr_entry, rd_entry;

  logic [7:0]    fwd_pgm;
  logic          drum_hit, qual_fwd, qual_rev, take;
  logic [2:0]    score;
  logic          found_n;
  logic [AW-1:0] best_n;
  logic [2:0]    score_n;
  logic          last_eval, drum_restart, scan_end;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign out_load   = (state_q == S_DONE) && (!out_valid_q || !out_stall_i);
  assign tbl_full   = (cnt_q == CW'(TableDepth));
  assign last_idx   = AW'(cnt_q - CW'(1));
  assign rev        = (op_q == OP_EXCL);
  assign end_addr   = rev ? '0 : last_idx;

  // Table store
  assign wr_entry = '{fm: is_fm_i, msb: bank_msb_i, lsb: bank_lsb_i,
                      pgm: program_req_i, drum: drum_note_i};
  assign ram_we   = in_acc && (op_i == OP_ADD) && !tbl_full;
  assign ram_addr = ram_we ? AW'(cnt_q) : addr_q;
  assign rd_entry = entry_t'(ram_rdata);

  vptl_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (wr_entry),
    .rdata_o (ram_rdata)
  );

  // Scoring of the entry returned by the RAM. Score bits are weighted so
  // that MSB > LSB > drum note, matching 1000 / 100 / 1.
  always_comb begin
    fwd_pgm  = drum_pass_q ? {1'b0, note_q[6:0]} : pgm_q;
    drum_hit = (rd_entry.drum != 8'd0) && (rd_entry.drum == note_q);
    qual_fwd = rd_entry.fm && (rd_entry.pgm == fwd_pgm);
    qual_rev = rd_entry.fm && (rd_entry.lsb == lsb_q) &&
               (rd_entry.pgm[6:0] == pgm_q[6:0]);
    score    = drum_pass_q ? {1'b0, 1'b1, drum_hit}
                           : {rd_entry.msb == msb_q, rd_entry.lsb == lsb_q, drum_hit};
    take     = pend_q && (rev ? qual_rev
                              : (qual_fwd && (!found_q || (score > score_q))));
    found_n  = found_q || take;
    best_n   = take ? pidx_q : best_q;
    score_n  = take ? score : score_q;
    last_eval    = pend_q && !issuing_q;
    drum_restart = !rev && last_eval && !drum_pass_q && !found_n && lsb_q[7];
    scan_end     = (rev && take) || (last_eval && !drum_restart);
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (((op_i == OP_BEST) || (op_i == OP_EXCL)) && (cnt_q != '0)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath
  always_comb begin
    cnt_d        = cnt_q;
    addr_d       = addr_q;
    pidx_d       = pidx_q;
    best_d       = best_q;
    score_d      = score_q;
    found_d      = found_q;
    pend_d       = pend_q;
    issuing_d    = issuing_q;
    drum_pass_d  = drum_pass_q;
    op_d         = op_q;
    msb_d        = msb_q;
    lsb_d        = lsb_q;
    pgm_d        = pgm_q;
    note_d       = note_q;
    res_status_d = res_status_q;
    res_idx_d    = res_idx_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          op_d        = op_i;
          msb_d       = bank_msb_i;
          lsb_d       = bank_lsb_i;
          pgm_d       = program_req_i;
          note_d      = note_i;
          found_d     = 1'b0;
          score_d     = '0;
          best_d      = '0;
          drum_pass_d = 1'b0;
          pend_d      = 1'b0;
          issuing_d   = 1'b1;
          addr_d      = (op_i == OP_EXCL) ? last_idx : '0;
          res_status_d = ST_NOTFOUND;
          res_idx_d    = 8'd0;
          if (op_i == OP_ADD) begin
            if (tbl_full) begin
              res_status_d = ST_FULL;
            end else begin
              cnt_d        = cnt_q + CW'(1);
              res_status_d = ST_OK;
              res_idx_d    = 8'(cnt_q);
            end
          end
        end
      end
      S_SCAN: begin
        if (issuing_q) begin
          pend_d = 1'b1;
          pidx_d = addr_q;
          if (addr_q == end_addr) begin
            issuing_d = 1'b0;
          end else begin
            addr_d = rev ? (addr_q - AW'(1)) : (addr_q + AW'(1));
          end
        end else begin
          pend_d = 1'b0;
        end
        found_d = found_n;
        best_d  = best_n;
        score_d = score_n;
        if (drum_restart) begin
          drum_pass_d = 1'b1;
          addr_d      = '0;
          issuing_d   = 1'b1;
          pend_d      = 1'b0;
        end
        if (scan_end) begin
          res_status_d = found_n ? ST_OK : ST_NOTFOUND;
          res_idx_d    = found_n ? 8'(best_n) : 8'd0;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      issuing_q   <= 1'b0;
      found_q     <= 1'b0;
      drum_pass_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_q      <= pend_d;
      issuing_q   <= issuing_d;
      found_q     <= found_d;
      drum_pass_q <= drum_pass_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q       <= addr_d;
    pidx_q       <= pidx_d;
    best_q       <= best_d;
    score_q      <= score_d;
    op_q         <= op_d;
    msb_q        <= msb_d;
    lsb_q        <= lsb_d;
    pgm_q        <= pgm_d;
    note_q       <= note_d;
    res_status_q <= res_status_d;
    res_idx_q    <= res_idx_d;
    if (out_load) begin
      out_status_q <= res_status_q;
      out_index_q  <= res_idx_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign entry_index_o = out_index_q;

endmodule

### design/vptl_checker.sv
// ----------------------------------------------------------------------------
// vptl_checker
// Port-level checks of the voice program table lookup, bound to the top.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module vptl_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [1:0] status_o,
  input logic [7:0] entry_index_o
);
  import vptl_pkg::*;

  logic       in_xfer, out_held, code_ok;
  logic [9:0] out_word;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_word = {status_o, entry_index_o};
  assign code_ok  = (status_o == ST_OK) || (status_o == ST_NOTFOUND) ||
                    (status_o == ST_FULL);

  // A transfer in makes the block busy until its result is loaded into the output register.
  `VPTL_ASSERT(a_busy_after_in, in_xfer |=> in_stall_o, "not busy after input transfer")

  `VPTL_ASSERT(a_out_hold, out_held |=> out_valid_o && $stable(out_word), "stalled result moved")

  `VPTL_ASSERT(a_status_code, out_valid_o |-> code_ok, "bad status code")

  // Failures carry index zero.
  `VPTL_ASSERT(a_idx_zero, out_valid_o && status_o != ST_OK |-> entry_index_o == 8'd0, "index set")

  `VPTL_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !out_valid_o, "result valid in reset")

endmodule

bind voice_program_table_lookup vptl_checker u_vptl_checker (.*);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the voice program table lookup. A short table of
// directed items is run first: lookups on an empty table, extreme fields,
// the spare op code, and the drum-pass, tie and bit-7 program cases. Random
// adds and lookups follow, enough that the table fills and refuses adds.
// The random part runs in phases of sender idling and receiver stalling.
// Results are checked against a behavioural table copy or typed answers.
// ----------------------------------------------------------------------------
module testbench;
  import vptl_pkg::*;

  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int Depth = TableDepthDefault;
  localparam int RandomItems = 1150;
  localparam int IdleLimit = 20000;
  localparam int TailCycles = 2 * Depth + 64;

  typedef struct packed {
    logic [1:0] op;
    logic       fm;
    logic [7:0] msb;
    logic [7:0] lsb;
    logic [7:0] pgm;
    logic [7:0] dnote;
    logic [7:0] note;
    logic       fixed;
    logic [1:0] fix_status;
    logic [7:0] fix_index;
  } voice_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] index;
  } table_answer_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i = 1'b0;
  logic       out_stall_i = 1'b0;
  voice_req_t cur_req = '0;
  logic       in_stall_o;
  logic       out_valid_o;
  logic [1:0] status_o;
  logic [7:0] entry_index_o;

  // behavioural copy of the table
  entry_t        voice_copy [Depth];
  int            stored_count = 0;
  table_answer_t pending_answers [$];
  voice_req_t    plan [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;
  int adds_done = 0, best_done = 0, excl_done = 0, spare_done = 0;
  int full_refusals = 0, lookups_found = 0, drum_pass_hits = 0;

  voice_program_table_lookup dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .op_i          (cur_req.op),
    .is_fm_i       (cur_req.fm),
    .bank_msb_i    (cur_req.msb),
    .bank_lsb_i    (cur_req.lsb),
    .program_req_i (cur_req.pgm),
    .drum_note_i   (cur_req.dnote),
    .note_i        (cur_req.note),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .status_o      (status_o),
    .entry_index_o (entry_index_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < sink_stall_pct);
  end

  // Applies one item to the table copy and returns the answer it gives.
  function automatic table_answer_t table_answer(input voice_req_t r);
    table_answer_t a;
    int            top_score;
    int            top_at;
    int            score;
    logic [7:0]    drum_pgm;
    a.status = ST_NOTFOUND;
    a.index  = '0;
    case (r.op)
      OP_ADD: begin
        if (stored_count >= Depth) begin
          a.status = ST_FULL;
        end else begin
          voice_copy[stored_count] = '{fm: r.fm, msb: r.msb, lsb: r.lsb,
                                       pgm: r.pgm, drum: r.dnote};
          a.status = ST_OK;
          a.index  = 8'(stored_count);
          stored_count++;
        end
      end
      OP_BEST: begin
        top_score = -1;
        top_at    = 0;
        for (int i = 0; i < stored_count; i++) begin
          if (voice_copy[i].fm && voice_copy[i].pgm == r.pgm) begin
            score = 0;
            if (voice_copy[i].msb == r.msb) score += 1000;
            if (voice_copy[i].lsb == r.lsb) score += 100;
            if (voice_copy[i].drum != 8'd0 && voice_copy[i].drum == r.note) score += 1;
            if (score > top_score) begin
              top_score = score;
              top_at    = i;
            end
          end
        end
        // drum pass: note picks the program, bank LSB counts as matched
        if (top_score < 0 && r.lsb >= 8'd128) begin
          drum_pgm = r.note & 8'h7F;
          for (int i = 0; i < stored_count; i++) begin
            if (voice_copy[i].fm && voice_copy[i].pgm == drum_pgm) begin
              score = 100;
              if (voice_copy[i].drum != 8'd0 && voice_copy[i].drum == r.note) score += 1;
              if (score > top_score) begin
                top_score = score;
                top_at    = i;
              end
            end
          end
          if (top_score >= 0) drum_pass_hits++;
        end
        if (top_score >= 0) begin
          a.status = ST_OK;
          a.index  = 8'(top_at);
        end
      end
      OP_EXCL: begin
        for (int i = stored_count - 1; i >= 0 && a.status != ST_OK; i--) begin
          if (voice_copy[i].fm && voice_copy[i].lsb == r.lsb &&
              voice_copy[i].pgm[6:0] == r.pgm[6:0]) begin
            a.status = ST_OK;
            a.index  = 8'(i);
          end
        end
      end
      default: ;
    endcase
    return a;
  endfunction

  always @(posedge clk_i) begin : monitor
    table_answer_t want;
    table_answer_t model;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_answers.size() == 0) begin
          errors++;
          $display("%0t: result with nothing pending: status %0d index %0d",
                   $time, status_o, entry_index_o);
        end else begin
          want = pending_answers.pop_front();
          if (status_o !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d got %0d",
                     $time, want.status, status_o);
          end
          if (entry_index_o !== want.index) begin
            errors++;
            $display("%0t: entry_index mismatch, expected %0d got %0d",
                     $time, want.index, entry_index_o);
          end
        end
      end
      if (in_valid_i && !in_stall_o) begin
        model = table_answer(cur_req);
        case (cur_req.op)
          OP_ADD:  adds_done++;
          OP_BEST: best_done++;
          OP_EXCL: excl_done++;
          default: spare_done++;
        endcase
        if (model.status == ST_FULL) full_refusals++;
        if (cur_req.op != OP_ADD && model.status == ST_OK) lookups_found++;
        // directed rows carry their answer typed in
        if (cur_req.fixed) begin
          model.status = cur_req.fix_status;
          model.index  = cur_req.fix_index;
        end
        pending_answers = {pending_answers, model};
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= IdleLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, IdleLimit);
      $display("voice_program_table_lookup regression: fail");
      $finish;
    end
  end

  function automatic voice_req_t row(input logic [1:0] op, input logic fm,
                                     input logic [7:0] msb, input logic [7:0] lsb,
                                     input logic [7:0] pgm, input logic [7:0] dnote,
                                     input logic [7:0] note, input logic fixed = 1'b0,
                                     input logic [1:0] st = ST_OK,
                                     input logic [7:0] idx = 8'd0);
    return '{op: op, fm: fm, msb: msb, lsb: lsb, pgm: pgm, dnote: dnote,
             note: note, fixed: fixed, fix_status: st, fix_index: idx};
  endfunction

  // Small value pools make programs and banks collide often.
  function automatic voice_req_t random_req();
    voice_req_t r;
    int         k;
    r = '0;
    k = $urandom_range(99);
    r.op = (k < 36) ? OP_ADD : (k < 66) ? OP_BEST : (k < 94) ? OP_EXCL : OP_SPARE;
    r.fm = ($urandom_range(99) < 80);
    if ($urandom_range(99) < 75)
      r.pgm = 8'($urandom_range(7)) | (($urandom_range(3) == 0) ? 8'h80 : 8'h00);
    else
      r.pgm = 8'($urandom);
    r.msb = ($urandom_range(99) < 60) ? 8'($urandom_range(2)) : 8'($urandom);
    if ($urandom_range(99) < 65) begin
      case ($urandom_range(3))
        0:       r.lsb = 8'd0;
        1:       r.lsb = 8'd127;
        2:       r.lsb = 8'd128;
        default: r.lsb = 8'd200;
      endcase
    end else begin
      r.lsb = 8'($urandom);
    end
    k = $urandom_range(99);
    r.dnote = (k < 40) ? 8'd0 : (k < 80) ? 8'(36 + $urandom_range(3)) : 8'($urandom);
    k = $urandom_range(99);
    if (k < 40) r.note = 8'(36 + $urandom_range(3));
    else if (k < 70) r.note = 8'($urandom_range(7)) | (($urandom_range(1) == 1) ? 8'h80 : 8'h00);
    else r.note = 8'($urandom);
    return r;
  endfunction

  function automatic void plan_row(input voice_req_t r);
    plan = {plan, r};
  endfunction

  task automatic offer_request(input voice_req_t r);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    cur_req    <= r;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Returns on a rising edge once every expected answer has arrived.
  task automatic wait_drained();
    do @(negedge clk_i); while (pending_answers.size() != 0);
    @(posedge clk_i);
  endtask

  initial begin : stimulus
    int phase;
    int last_phase;
    rst_ni <= 1'b0;
    // empty table, the spare op code, then the entries added for what follows
    plan_row(row(OP_BEST, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_NOTFOUND));
    plan_row(row(OP_EXCL, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_NOTFOUND));
    plan_row(row(OP_BEST, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                 1'b1, ST_NOTFOUND));
    plan_row(row(OP_SPARE, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255,
                 1'b1, ST_NOTFOUND));
    plan_row(row(OP_ADD, 1'b1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_OK, 8'd0));
    plan_row(row(OP_ADD, 1'b1, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0,
                 1'b1, ST_OK, 8'd1));
    plan_row(row(OP_ADD, 1'b0, 8'd1, 8'd130, 8'd5, 8'd60, 8'd0, 1'b1, ST_OK, 8'd2));
    plan_row(row(OP_ADD, 1'b1, 8'd1, 8'd130, 8'd5, 8'd60, 8'd0, 1'b1, ST_OK, 8'd3));
    plan_row(row(OP_ADD, 1'b1, 8'd2, 8'd130, 8'd5, 8'd5, 8'd0, 1'b1, ST_OK, 8'd4));
    plan_row(row(OP_ADD, 1'b1, 8'd1, 8'd7, 8'h85, 8'd61, 8'd0, 1'b1, ST_OK, 8'd5));
    // scoring, ties and the drum pass
    plan_row(row(OP_BEST, 1'b0, 8'd1, 8'd130, 8'd5, 8'd0, 8'd60));
    plan_row(row(OP_BEST, 1'b0, 8'd2, 8'd9, 8'd5, 8'd0, 8'd60));
    plan_row(row(OP_BEST, 1'b0, 8'd9, 8'd9, 8'd5, 8'd0, 8'd0));
    plan_row(row(OP_BEST, 1'b0, 8'd0, 8'd200, 8'd9, 8'd0, 8'h85));
    plan_row(row(OP_BEST, 1'b0, 8'd0, 8'd127, 8'd9, 8'd0, 8'd5));
    plan_row(row(OP_BEST, 1'b0, 8'd0, 8'd128, 8'd9, 8'd0, 8'd5));
    plan_row(row(OP_BEST, 1'b0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255));
    // exclusive lookups: newest first, program compared on 7 bits
    plan_row(row(OP_EXCL, 1'b0, 8'd0, 8'd130, 8'h85, 8'd0, 8'd0));
    plan_row(row(OP_EXCL, 1'b0, 8'd0, 8'd7, 8'd5, 8'd0, 8'd0));
    plan_row(row(OP_EXCL, 1'b0, 8'd0, 8'd130, 8'd6, 8'd0, 8'd0));
    plan_row(row(OP_EXCL, 1'b0, 8'd0, 8'd0, 8'h80, 8'd0, 8'd0));
    plan_row(row(OP_SPARE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, ST_NOTFOUND));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (plan[i]) offer_request(plan[i]);

    last_phase = -1;
    for (int i = 0; i < RandomItems; i++) begin
      phase = i * 4 / RandomItems;
      if (phase != last_phase) begin
        // hold off until the block has answered everything
        in_valid_i <= 1'b0;
        wait_drained();
        case (phase)
          0:       begin src_idle_pct = 0;  sink_stall_pct = 0;  end
          1:       begin src_idle_pct = 80; sink_stall_pct = 0;  end
          2:       begin src_idle_pct = 0;  sink_stall_pct = 80; end
          default: begin src_idle_pct = 18; sink_stall_pct = 18; end
        endcase
        last_phase = phase;
      end
      offer_request(random_req());
    end
    in_valid_i <= 1'b0;
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);
    @(negedge clk_i);

    $display("covered %0d adds (%0d refused full), %0d best, %0d exclusive, %0d spare op",
             adds_done, full_refusals, best_done, excl_done, spare_done);
    $display("%0d lookups hit an entry, %0d via the drum pass; %0d mismatches",
             lookups_found, drum_pass_hits, errors);
    if (errors == 0 && pending_answers.size() == 0) begin
      $display("voice_program_table_lookup regression: pass");
    end else begin
      if (pending_answers.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_answers.size());
      $display("voice_program_table_lookup regression: fail");
    end
    $finish;
  end

endmodule

### voice_program_table_lookup.f
+incdir+design
design/vptl_pkg.sv
design/vptl_ram.sv
design/voice_program_table_lookup.sv
design/vptl_checker.sv
tb/testbench.sv
